FILE: design/tsh_pkg.sv
// Package for the TEA string hash block.
// Holds the hash constants, the length width and the round arithmetic.
// No dependencies.
package tsh_pkg;

   localparam int LENGTH_BITS = 31;

   localparam logic [31:0] TEA_DELTA   = 32'h9E37_79B9;
   localparam logic [31:0] HASH_A_INIT = 32'h9464_a485;
   localparam logic [31:0] HASH_B_INIT = 32'h542e_1a94;

   localparam int BLOCK_ROUNDS = 6;
   localparam int FINAL_ROUNDS = 10;

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

   typedef logic [7:0]  byte_type;
   typedef logic [31:0] word_type;

   // One half of a TEA round: acc plus the mix of v with the two keys.
   function automatic word_type tea_half(input word_type acc, input word_type v,
                                         input word_type ka, input word_type kb,
                                         input word_type sum);
      tea_half = acc + (((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb));
   endfunction

   // Little-endian word from four bytes.
   function automatic word_type le_word(input byte_type b0, input byte_type b1,
                                        input byte_type b2, input byte_type b3);
      le_word = {b3, b2, b1, b0};
   endfunction

   // Tail word of a partial block: the pad shifted in by rem sign-extended bytes.
   function automatic word_type tail_word(input word_type pad, input byte_type b0,
                                          input byte_type b1, input byte_type b2,
                                          input logic [1:0] rem);
      word_type w;
      w = pad;
      if (rem > 2'd0) w = (w << 8) | {{24{b0[7]}}, b0};
      if (rem > 2'd1) w = (w << 8) | {{24{b1[7]}}, b1};
      if (rem > 2'd2) w = (w << 8) | {{24{b2[7]}}, b2};
      tail_word = w;
   endfunction

endpackage

FILE: design/tea_string_hash.sv
// TEA string hash, top level.
// Uses tsh_pkg for constants and the round arithmetic.
//
// Usage:
//   req_* carries one message byte per item (req_data_byte), or no byte when
//   req_no_data is set; req_last ends the message. rsp_* returns one 32-bit
//   hash per message, after its last item.
//   A byte that neither completes a 16-byte block nor ends the message leaves
//   the sequencer idle. A byte that completes a block is followed by loading the
//   block words, the six TEA rounds on the shared round unit (one half-round
//   per cycle) and the feed-forward add. The last item is followed by setting
//   up the tail, ten rounds and the add when a partial block is left, and
//   posting the hash.
//   req_ready is high only while the sequencer is idle.
//   rsp_valid holds with rsp_hash_value until rsp_ready; bytes of the next
//   message are taken meanwhile, and only posting the next hash waits.
//   Reset (synchronous) returns the hash words and length to their initial
//   values and drops any pending result. The length saturates at
//   2^LENGTH_BITS - 1; bytes beyond it are dropped.
module tea_string_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_no_data,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_value
);
   import tsh_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_MIX, ST_FEED, ST_FIN, ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   word_type             hash_a_ff, hash_a_in;
   word_type             hash_b_ff, hash_b_in;
   byte_type             block_ff [16];
   byte_type             block_in [16];
   word_type             w_ff [4];
   word_type             w_in [4];
   word_type             x_ff, x_in, y_ff, y_in, sum_ff, sum_in;
   logic                 phase_ff, phase_in;
   logic [3:0]           round_ff, round_in;
   logic                 last_ff, last_in;
   logic                 final_ff, final_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   word_type             rsp_hash_ff, rsp_hash_in;

   logic                 accept;
   logic                 take;
   logic [3:0]           round_limit;
   word_type             half_out;
   word_type             pad;
   logic [1:0]           nfull;
   logic [1:0]           rem;
   word_type             full_w [4];
   word_type             tail_w [4];

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   assign accept = req_valid && req_ready;
   assign take   = !req_no_data && (count_ff != COUNT_MAX);

   assign round_limit = final_ff ? 4'(FINAL_ROUNDS - 1) : 4'(BLOCK_ROUNDS - 1);

   // Shared half-round unit: x update in phase 0, y update in phase 1.
   assign half_out = phase_ff ? tea_half(y_ff, x_ff, w_ff[2], w_ff[3], sum_ff)
                              : tea_half(x_ff, y_ff, w_ff[0], w_ff[1], sum_ff);

   assign pad   = {4{count_ff[7:0]}};
   assign nfull = count_ff[3:2];
   assign rem   = count_ff[1:0];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         full_w[j] = le_word(block_ff[4*j], block_ff[4*j+1],
                             block_ff[4*j+2], block_ff[4*j+3]);
         tail_w[j] = tail_word(pad, block_ff[4*j], block_ff[4*j+1],
                               block_ff[4*j+2], rem);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      hash_a_in    = hash_a_ff;
      hash_b_in    = hash_b_ff;
      block_in     = block_ff;
      w_in         = w_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      sum_in       = sum_ff;
      phase_in     = phase_ff;
      round_in     = round_ff;
      last_in      = last_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_last;
               if (take) begin
                  block_in[count_ff[3:0]] = req_data_byte;
                  count_in = count_ff + 1'b1;
               end
               if (take && (count_ff[3:0] == 4'hF)) state_in = ST_LOAD;
               else if (req_last)                   state_in = ST_FIN;
            end
         end
         ST_LOAD: begin
            w_in     = full_w;
            x_in     = hash_a_ff;
            y_in     = hash_b_ff;
            sum_in   = TEA_DELTA;
            phase_in = 1'b0;
            round_in = '0;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            if (!phase_ff) begin
               x_in     = half_out;
               phase_in = 1'b1;
            end else begin
               y_in     = half_out;
               phase_in = 1'b0;
               sum_in   = sum_ff + TEA_DELTA;
               round_in = round_ff + 1'b1;
               if (round_ff == round_limit) state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            hash_a_in = hash_a_ff + x_ff;
            hash_b_in = hash_b_ff + y_ff;
            if (!last_ff)      state_in = ST_IDLE;
            else if (final_ff) state_in = ST_DONE;
            else               state_in = ST_FIN;
         end
         ST_FIN: begin
            if (count_ff[3:0] == 4'h0) begin
               state_in = ST_DONE;
            end else begin
               for (int j = 0; j < 4; j++) begin
                  if (2'(j) < nfull)       w_in[j] = full_w[j];
                  else if (2'(j) == nfull) w_in[j] = tail_w[j];
                  else                     w_in[j] = pad;
               end
               x_in     = hash_a_ff;
               y_in     = hash_b_ff;
               sum_in   = TEA_DELTA;
               phase_in = 1'b0;
               round_in = '0;
               final_in = 1'b1;
               state_in = ST_MIX;
            end
         end
         ST_DONE: begin
            // wait for the output slot to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = hash_a_ff ^ hash_b_ff;
               hash_a_in    = HASH_A_INIT;
               hash_b_in    = HASH_B_INIT;
               count_in     = '0;
               last_in      = 1'b0;
               final_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      block_ff    <= block_in;
      w_ff        <= w_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      sum_ff      <= sum_in;
      phase_ff    <= phase_in;
      round_ff    <= round_in;
      rsp_hash_ff <= rsp_hash_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         hash_a_ff    <= HASH_A_INIT;
         hash_b_ff    <= HASH_B_INIT;
         last_ff      <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hash_a_ff    <= hash_a_in;
         hash_b_ff    <= hash_b_in;
         last_ff      <= last_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: dv/tsh_checker.sv
// Checker for the TEA string hash block: watches both channels, predicts each hash
// from the accepted items and compares it with the returned one.
// Depends on tsh_pkg for the hash constants and the length width.
`timescale 1ns / 1ps

module tsh_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_no_data,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_hash_value,
   output int          error_count,
   output int          hashes_pending
);
   import tsh_pkg::*;

   word_type                 acc_a;
   word_type                 acc_b;
   byte_type                 blk [16];
   logic [LENGTH_BITS-1:0]   msg_len;
   word_type                 hash_queue [$];

   task automatic clear_message();
      acc_a = HASH_A_INIT;
      acc_b = HASH_B_INIT;
      msg_len = '0;
      for (int i = 0; i < 16; i++) blk[i] = '0;
   endtask

   task automatic tea_rounds(input word_type k0, input word_type k1, input word_type k2,
                             input word_type k3, input int rounds);
      word_type s;
      word_type x;
      word_type y;
      s = '0;
      x = acc_a;
      y = acc_b;
      for (int n = 0; n < rounds; n++) begin
         s = s + TEA_DELTA;
         x = x + (((y << 4) + k0) ^ (y + s) ^ ((y >> 5) + k1));
         y = y + (((x << 4) + k2) ^ (x + s) ^ ((x >> 5) + k3));
      end
      acc_a = acc_a + x;
      acc_b = acc_b + y;
   endtask

   function automatic word_type blk_word(input int base);
      blk_word = {blk[base + 3], blk[base + 2], blk[base + 1], blk[base]};
   endfunction

   // Mixes the partial block, if any, and queues the expected hash.
   task automatic close_message();
      int       r;
      int       nfull;
      int       rem;
      word_type pad;
      word_type tail [4];
      r = int'(msg_len[3:0]);
      if (r != 0) begin
         pad = {4{msg_len[7:0]}};
         nfull = r / 4;
         rem = r % 4;
         for (int j = 0; j < 4; j++) begin
            if (j < nfull) begin
               tail[j] = blk_word(j * 4);
            end else if (j == nfull) begin
               tail[j] = pad;
               for (int k = 0; k < rem; k++)
                  tail[j] = (tail[j] << 8) | {{24{blk[nfull * 4 + k][7]}}, blk[nfull * 4 + k]};
            end else begin
               tail[j] = pad;
            end
         end
         tea_rounds(tail[0], tail[1], tail[2], tail[3], FINAL_ROUNDS);
      end
      hash_queue.push_back(acc_a ^ acc_b);
      clear_message();
   endtask

   task automatic take_item();
      if (!req_no_data && msg_len != COUNT_MAX) begin
         blk[msg_len[3:0]] = req_data_byte;
         msg_len = msg_len + 1'b1;
         if (msg_len[3:0] == 4'd0)
            tea_rounds(blk_word(0), blk_word(4), blk_word(8), blk_word(12), BLOCK_ROUNDS);
      end
      if (req_last) close_message();
   endtask

   always @(posedge clock) begin
      word_type want;
      if (reset) begin
         clear_message();
         hash_queue.delete();
         error_count = 0;
         hashes_pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (hash_queue.size() == 0) begin
               $error("hash_value: no hash expected, actual %08h", rsp_hash_value);
               error_count = error_count + 1;
            end else begin
               want = hash_queue.pop_front();
               if (rsp_hash_value !== want) begin
                  $error("hash_value: expected %08h, actual %08h", want, rsp_hash_value);
                  error_count = error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) take_item();
         hashes_pending <= hash_queue.size();
      end
   end

endmodule

FILE: dv/tb.sv
// Testbench top for the TEA string hash block: clock, reset, byte stimulus and
// result back-pressure; the verdict comes from the failure count of tsh_checker.
// Depends on tea_string_hash, tsh_checker and tsh_pkg.
`timescale 1ns / 1ps

module tb;

   localparam int ITEM_TARGET = 1950;
   localparam int QUIET_FROM  = 1750;
   localparam int PAUSE_AT    = 900;
   localparam int CYCLE_LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_no_data = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [31:0] rsp_hash_value;

   int error_count;
   int hashes_pending;
   int items_sent = 0;
   int cycles = 0;
   int rsp_stall = 0;
   bit quiet = 1'b0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   bit paused = 1'b0;

   tea_string_hash i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_no_data    (req_no_data),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

   tsh_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_no_data    (req_no_data),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .error_count    (error_count),
      .hashes_pending (hashes_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Result side back-pressure: stall bursts, calm stretches, none at the end.
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else if (!rsp_calm && $urandom_range(0, 4) == 0) begin
         rsp_stall = $urandom_range(1, 13) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
      if ($urandom_range(0, 59) == 0) rsp_calm = ~rsp_calm;
   end

   task automatic send_item(input logic [7:0] d, input logic nd, input logic lst);
      int gap;
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_no_data   <= nd;
      req_last      <= lst;
      do @(posedge clock); while (!req_ready);
      items_sent = items_sent + 1;
      if (!quiet && !req_calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       pick_byte = 8'h00;
         1:       pick_byte = 8'hFF;
         2:       pick_byte = 8'h80;
         3:       pick_byte = 8'h7F;
         default: pick_byte = 8'($urandom());
      endcase
   endfunction

   // One message of len bytes with stray no-data items; closed on the last byte
   // or by a separate no-data item.
   task automatic send_message(input int len);
      bit close_on_byte;
      close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0) send_item(8'($urandom()), 1'b1, 1'b0);
         send_item(pick_byte(), 1'b0, close_on_byte && (i == len - 1));
      end
      if (!close_on_byte) send_item(8'($urandom()), 1'b1, 1'b1);
   endtask

   initial begin
      int len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message
      send_item(8'hA5, 1'b1, 1'b1);
      // no-data item alone, then a negative byte that also ends the message
      send_item(8'h3C, 1'b1, 1'b0);
      send_item(8'h80, 1'b0, 1'b1);
      // three-byte tail with both sign cases
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h7F, 1'b0, 1'b1);
      // exactly one block, no partial tail
      for (int i = 0; i < 16; i++) send_item(8'(i * 17), 1'b0, i == 15);

      while (items_sent < ITEM_TARGET) begin
         req_calm = ($urandom_range(0, 3) == 0);
         if (items_sent >= QUIET_FROM) quiet = 1'b1;
         if (!paused && items_sent >= PAUSE_AT) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (hashes_pending != 0) @(posedge clock);
         end
         if ($urandom_range(0, 9) == 0) len = $urandom_range(41, 80);
         else len = $urandom_range(0, 40);
         send_message(len);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (hashes_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
